/* rtl/bzpt_pkg.sv */
`default_nettype none
package bzpt_pkg;
  localparam int MaxPointsDefault = 8;
  localparam int TOne = 65536;
  localparam int DirOne = 16384;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic start;
    logic load_w;
    logic step_mul;
    logic step_wr;
    logic grab_diff;
    logic norm_init;
    logic norm_step;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic finish;
  } bzpt_cmd_t;

  typedef struct packed {
    logic last_i;
    logic last_k;
    logic deg_zero;
    logic norm_done;
    logic sqrt_done;
    logic div_done;
    logic zero_diff;
  } bzpt_sts_t;
endpackage
`default_nettype wire

/* rtl/bzpt_datapath.sv */
`default_nettype none
module bzpt_datapath #(
  parameter int MaxPoints = bzpt_pkg::MaxPointsDefault
) (
  input  wire logic                 clk,
  input  wire bzpt_pkg::bzpt_cmd_t  cmd,
  output bzpt_pkg::bzpt_sts_t       sts,
  input  wire logic [2:0]           curve_degree,
  input  wire logic [2:0]           point_index,
  input  wire logic signed [31:0]   point_x,
  input  wire logic signed [31:0]   point_y,
  input  wire logic [16:0]          t_param,
  output logic signed [31:0]        pos_x,
  output logic signed [31:0]        pos_y,
  output logic signed [15:0]        dir_x,
  output logic signed [15:0]        dir_y,
  output logic                      degenerate
);
  import bzpt_pkg::*;
  localparam int IW = $clog2(MaxPoints);

  logic signed [31:0] mem_x [MaxPoints];
  logic signed [31:0] mem_y [MaxPoints];
  logic signed [33:0] wx [MaxPoints];
  logic signed [33:0] wy [MaxPoints];
  logic [IW-1:0] ki;
  logic [IW-1:0] ii;
  logic [16:0] tq;
  logic signed [52:0] px_a, px_b, py_a, py_b;
  logic signed [34:0] dx, dy;
  logic [33:0] ax, ay;
  logic nx, ny;
  logic [63:0] sq_s, sq_r, sq_bit;
  logic [31:0] len;
  logic [5:0] dcnt;
  logic [47:0] remx, remy;
  logic [47:0] numx, numy;
  logic [17:0] qx, qy;

  logic [IW-1:0] nclamp;
  logic signed [53:0] sumx, sumy;
  logic signed [53:0] rx, ry;
  logic [33:0] mag;
  logic [63:0] sq_rb;
  logic [48:0] tx, ty;

  always_comb begin
    if (MaxPoints > 7) nclamp = IW'(curve_degree);
    else if ({29'd0, curve_degree} > 32'(MaxPoints - 1)) nclamp = IW'(MaxPoints - 1);
    else nclamp = IW'(curve_degree);
    sumx = {px_a[52], px_a} + {px_b[52], px_b} + 54'sd32768;
    sumy = {py_a[52], py_a} + {py_b[52], py_b} + 54'sd32768;
    rx = sumx >>> 16;
    ry = sumy >>> 16;
    mag = (ax > ay) ? ax : ay;
    sq_rb = sq_r + sq_bit;
    tx = {remx, numx[47]} - {17'd0, len};
    ty = {remy, numy[47]} - {17'd0, len};
  end

  assign sts.last_i = (ii + IW'(1) == ki);
  assign sts.last_k = (ki == IW'(1));
  assign sts.deg_zero = (ki == '0);
  assign sts.zero_diff = (mag == '0);
  assign sts.norm_done = (mag[33:31] == 3'd0) && mag[30];
  assign sts.sqrt_done = (sq_bit == '0);
  assign sts.div_done = (dcnt == 6'd0);

  always_ff @(posedge clk) begin
    if (cmd.load_w && {29'd0, point_index} < 32'(MaxPoints)) begin
      mem_x[IW'(point_index)] <= point_x;
      mem_y[IW'(point_index)] <= point_y;
    end
    if (cmd.start) begin
      for (int j = 0; j < MaxPoints; j++) begin
        wx[j] <= 34'(mem_x[j]);
        wy[j] <= 34'(mem_y[j]);
      end
      ki <= nclamp;
      ii <= '0;
      tq <= (t_param > 17'(TOne)) ? 17'(TOne) : t_param;
      dx <= '0;
      dy <= '0;
    end
    if (cmd.grab_diff) begin
      dx <= 35'(wx[1]) - 35'(wx[0]);
      dy <= 35'(wy[1]) - 35'(wy[0]);
    end
    if (cmd.step_mul) begin
      px_a <= $signed({1'b0, 17'(TOne) - tq}) * wx[ii];
      px_b <= $signed({1'b0, tq}) * wx[ii + IW'(1)];
      py_a <= $signed({1'b0, 17'(TOne) - tq}) * wy[ii];
      py_b <= $signed({1'b0, tq}) * wy[ii + IW'(1)];
    end
    if (cmd.step_wr) begin
      wx[ii] <= 34'(rx);
      wy[ii] <= 34'(ry);
      if (sts.last_i) begin
        ii <= '0;
        ki <= ki - IW'(1);
      end else begin
        ii <= ii + IW'(1);
      end
    end
    if (cmd.norm_init) begin
      nx <= dx[34];
      ny <= dy[34];
      ax <= 34'(dx[34] ? -dx : dx);
      ay <= 34'(dy[34] ? -dy : dy);
    end
    if (cmd.norm_step) begin
      if (mag[33:31] != 3'd0) begin
        ax <= ax >> 1;
        ay <= ay >> 1;
      end else begin
        ax <= ax << 1;
        ay <= ay << 1;
      end
    end
    if (cmd.sqrt_init) begin
      sq_s <= {32'd0, ax[31:0]} * {32'd0, ax[31:0]}
            + {32'd0, ay[31:0]} * {32'd0, ay[31:0]};
      sq_r <= '0;
      sq_bit <= 64'd1 << 62;
    end
    if (cmd.sqrt_step) begin
      if (sq_s >= sq_rb) begin
        sq_s <= sq_s - sq_rb;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_init) begin
      len <= sq_r[31:0];
      numx <= {2'd0, ax[31:0], 14'd0} + {17'd0, sq_r[31:1]};
      numy <= {2'd0, ay[31:0], 14'd0} + {17'd0, sq_r[31:1]};
      remx <= '0;
      remy <= '0;
      qx <= '0;
      qy <= '0;
      dcnt <= 6'd48;
    end
    if (cmd.div_step) begin
      numx <= numx << 1;
      numy <= numy << 1;
      if (!tx[48]) begin
        remx <= tx[47:0];
        qx <= {qx[16:0], 1'b1};
      end else begin
        remx <= {remx[46:0], numx[47]};
        qx <= {qx[16:0], 1'b0};
      end
      if (!ty[48]) begin
        remy <= ty[47:0];
        qy <= {qy[16:0], 1'b1};
      end else begin
        remy <= {remy[46:0], numy[47]};
        qy <= {qy[16:0], 1'b0};
      end
      dcnt <= dcnt - 6'd1;
    end
    if (cmd.finish) begin
      pos_x <= wx[0][31:0];
      pos_y <= wy[0][31:0];
      if (sts.zero_diff) begin
        dir_x <= 16'(DirOne);
        dir_y <= '0;
        degenerate <= 1'b1;
      end else begin
        dir_x <= nx ? -((qx > 18'(DirOne)) ? 16'(DirOne) : qx[15:0])
                    : ((qx > 18'(DirOne)) ? 16'(DirOne) : qx[15:0]);
        dir_y <= ny ? -((qy > 18'(DirOne)) ? 16'(DirOne) : qy[15:0])
                    : ((qy > 18'(DirOne)) ? 16'(DirOne) : qy[15:0]);
        degenerate <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/bzpt_ctrl.sv */
`default_nettype none
module bzpt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                func,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire bzpt_pkg::bzpt_sts_t sts,
  output bzpt_pkg::bzpt_cmd_t      cmd
);
  import bzpt_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_WR   = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state, state_next;
  logic busy;
  logic acc;

  assign busy = (state != S_IDLE);
  assign in_stall = busy || (out_valid && out_stall);
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (func == FUNC_LOAD) begin
            cmd.load_w = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (sts.deg_zero) begin
          cmd.norm_init = 1'b1;
          state_next = S_NORM;
        end else begin
          cmd.step_mul = 1'b1;
          if (sts.last_k && sts.last_i) cmd.grab_diff = 1'b1;
          state_next = S_WR;
        end
      end
      S_WR: begin
        cmd.step_wr = 1'b1;
        state_next = S_MUL;
      end
      S_NORM: begin
        if (sts.zero_diff) begin
          state_next = S_FIN;
        end else if (sts.norm_done) begin
          cmd.sqrt_init = 1'b1;
          state_next = S_SQRT;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.div_init = 1'b1;
          state_next = S_DIV;
        end else begin
          cmd.sqrt_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/bezier_point_and_tangent_core.sv */
// Sequence: a load writes its point in the cycle it is accepted. An evaluation
// runs the de Casteljau loop, then normalize shifts, square root steps and
// divider steps, all on one shared datapath.
// Throughput: one item at a time; the next is accepted once the result leaves.
// Reset (rst, synchronous) clears the controller and sets curve_degree to 3.
`default_nettype none
module bezier_point_and_tangent_core #(
  parameter int MaxPoints = bzpt_pkg::MaxPointsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic [2:0]         point_index,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic [16:0]        t_param,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [15:0]      dir_x,
  output logic signed [15:0]      dir_y,
  output logic                    degenerate
);
  import bzpt_pkg::*;
  bzpt_cmd_t cmd;
  bzpt_sts_t sts;
  logic [2:0] curve_degree;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) curve_degree <= 3'd3;
    else if (cfg_valid && cfg_ready) curve_degree <= cfg_data;
  end

  bzpt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .func, .out_valid, .out_stall, .sts, .cmd
  );

  bzpt_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk, .cmd, .sts, .curve_degree, .point_index, .point_x, .point_y,
    .t_param, .pos_x, .pos_y, .dir_x, .dir_y, .degenerate
  );
endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb;
  import bzpt_pkg::*;

  localparam int WatchLimit = 6000;
  localparam int DrainCycles = 250;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic               degen;
  } curve_res_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               f;
    logic [2:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [16:0]        t;
    bit                 typed;
    curve_res_t         res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic func = FUNC_LOAD;
  logic [2:0] point_index = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic [16:0] t_param = '0;
  logic out_stall = 1'b0;
  logic cfg_ready, in_stall, out_valid, degenerate;
  logic signed [31:0] pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y;

  bezier_point_and_tangent_core dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data, .in_valid, .in_stall,
    .func, .point_index, .point_x, .point_y, .t_param, .out_valid, .out_stall,
    .pos_x, .pos_y, .dir_x, .dir_y, .degenerate
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  curve_res_t pending_curves[$];
  longint ctrl_x[8];
  longint ctrl_y[8];
  int cur_degree = 3;
  int errors = 0;
  int evals_checked = 0;
  int loads_sent = 0;
  int degen_seen = 0;
  bit quiet = 0;
  bit long_hold_req = 0;
  stim_row_t rows[$];

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic void casteljau_axis(input longint pts[8], input int n, input longint t,
                                         output longint pos, output longint diff);
    longint w[8];
    longint u;
    u = 65536 - t;
    for (int i = 0; i < 8; i++) w[i] = pts[i];
    diff = 0;
    for (int k = n; k >= 1; k--) begin
      if (k == 1) diff = w[1] - w[0];
      for (int i = 0; i < k; i++) w[i] = round_q16(u * w[i] + t * w[i + 1]);
    end
    pos = w[0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] unit_part(longint unsigned mag, bit neg,
                                                   longint unsigned len);
    longint unsigned q;
    q = (mag * DirOne + len / 2) / len;
    if (q > DirOne) q = DirOne;
    return neg ? -16'(q) : 16'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic curve_res_t eval_curve(logic [16:0] tp);
    curve_res_t r;
    longint t, px, py, ddx, ddy;
    longint unsigned ax, ay, m, len;
    bit nx, ny;
    t = tp;
    if (t > TOne) t = TOne;
    casteljau_axis(ctrl_x, cur_degree, t, px, ddx);
    casteljau_axis(ctrl_y, cur_degree, t, py, ddy);
    r.px = 32'(sat32(px));
    r.py = 32'(sat32(py));
    nx = ddx < 0;
    ny = ddy < 0;
    ax = nx ? -ddx : ddx;
    ay = ny ? -ddy : ddy;
    m = ax > ay ? ax : ay;
    if (m == 0) begin
      r.dx = 16'(DirOne);
      r.dy = 0;
      r.degen = 1'b1;
    end else begin
      while (m >= 64'h8000_0000) begin
        ax = ax >> 1; ay = ay >> 1; m = m >> 1;
      end
      while (m < 64'h4000_0000) begin
        ax = ax << 1; ay = ay << 1; m = m << 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      r.dx = unit_part(ax, nx, len);
      r.dy = unit_part(ay, ny, len);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  task automatic transfer_item(logic f, logic [2:0] idx, logic signed [31:0] x,
                               logic signed [31:0] y, logic [16:0] t, bit typed,
                               curve_res_t res);
    int gap, r;
    @(negedge clk);
    in_valid = 1'b1;
    func = f;
    point_index = idx;
    point_x = x;
    point_y = y;
    t_param = t;
    do @(posedge clk); while (in_stall);
    if (f == FUNC_LOAD) begin
      ctrl_x[idx] = x;
      ctrl_y[idx] = y;
      loads_sent++;
    end else begin
      pending_curves.insert(pending_curves.size(), typed ? res : eval_curve(t));
    end
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 60 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_degree(int d);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_curves.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = 3'(d);
    do @(posedge clk); while (!cfg_ready);
    cur_degree = d;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 17'd0;
    if (r == 1) return 17'(TOne);
    if (r == 2) return 17'($urandom_range(TOne + 1, 131071));
    return 17'($urandom_range(0, TOne));
  endfunction

  task automatic add_row(row_kind_t kind, logic f, logic [2:0] idx, logic signed [31:0] x,
                         logic signed [31:0] y, logic [16:0] t, bit typed,
                         logic signed [31:0] ex, logic signed [31:0] ey);
    stim_row_t s;
    s.kind = kind; s.f = f; s.idx = idx; s.x = x; s.y = y; s.t = t; s.typed = typed;
    s.res.px = ex; s.res.py = ey; s.res.dx = 16'(DirOne); s.res.dy = 0; s.res.degen = 1'b1;
    rows.insert(rows.size(), s);
  endtask

  always @(negedge clk) begin : receiver
    static int hold_cnt = 0;
    int r;
    if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_cnt = r < 95 ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    curve_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_curves.size() == 0) begin
        $error("result with nothing expected: pos_x=%0d pos_y=%0d", pos_x, pos_y);
        errors++;
      end else begin
        e = pending_curves.pop_front();
        evals_checked++;
        if (degenerate) degen_seen++;
        if (pos_x !== e.px) begin
          $error("pos_x expected %0d actual %0d", e.px, pos_x); errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y expected %0d actual %0d", e.py, pos_y); errors++;
        end
        if (dir_x !== e.dx) begin
          $error("dir_x expected %0d actual %0d", e.dx, dir_x); errors++;
        end
        if (dir_y !== e.dy) begin
          $error("dir_y expected %0d actual %0d", e.dy, dir_y); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, degenerate); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    static int idle_cycles = 0;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    curve_res_t none;
    logic signed [31:0] v;
    none = '{default: '0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 8; i++)
      add_row(ROW_ITEM, FUNC_LOAD, 3'(i), 32'sh1234_5678, 32'shffff_0000, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd30000, 1, 32'sh1234_5678, 32'shffff_0000);
    add_row(ROW_ITEM, FUNC_LOAD, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 1, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 2, 0, -1, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 3, -1, 1, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 4, 32'sh0001_0000, 32'sh5555_aaaa, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 5, 32'shaaaa_5555, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 6, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_LOAD, 7, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd65536, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'h1ffff, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd32768, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd1, 0, 0, 0);
    add_row(ROW_CFG, 0, 3'd0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd12345, 1, 32'sh7fff_ffff, 32'sh8000_0000);
    add_row(ROW_CFG, 0, 3'd7, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, FUNC_EVAL, 0, 0, 0, 17'd40000, 0, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG)
        write_degree(rows[i].idx);
      else
        transfer_item(rows[i].f, rows[i].idx, rows[i].x, rows[i].y, rows[i].t,
                      rows[i].typed, rows[i].res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      write_degree(ph == 0 ? 7 : ph == 1 ? 0 : ph == 2 ? 3 : $urandom_range(0, 7));
      quiet = (ph == 4);
      for (int n = 0; n < 220; n++) begin
        if (ph == 2 && n == 50) long_hold_req = 1;
        if ($urandom_range(0, 39) == 0) begin
          v = rand_coord();
          for (int i = 0; i < 8; i++) transfer_item(FUNC_LOAD, 3'(i), v, v, 0, 0, none);
        end else if ($urandom_range(0, 9) < 3) begin
          transfer_item(FUNC_LOAD, 3'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                        17'($urandom), 0, none);
        end else begin
          transfer_item(FUNC_EVAL, 3'($urandom_range(0, 7)), $urandom, $urandom,
                        rand_t(), 0, none);
        end
      end
      quiet = 0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_curves.size() == 0);
    repeat (DrainCycles) @(negedge clk);
    if (pending_curves.size() != 0) begin
      $error("%0d expected results never arrived", pending_curves.size());
      errors++;
    end
    $display("tb: %0d control point loads, %0d curve evaluations checked (%0d degenerate)",
             loads_sent, evals_checked, degen_seen);
    $display("tb: degrees 0 to 7 with stalls, gaps and one long output hold");
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule

/* bezier_point_and_tangent_core.f */
rtl/bzpt_pkg.sv
rtl/bzpt_datapath.sv
rtl/bzpt_ctrl.sv
rtl/bezier_point_and_tangent_core.sv
verif/tb.sv
